// File: rtl/pinhole_point_projection_defines.svh
// Assertion macros for the pinhole point projection block.
// Used by the top level only; no other dependencies.
`ifndef PINHOLE_POINT_PROJECTION_DEFINES_SVH
`define PINHOLE_POINT_PROJECTION_DEFINES_SVH

// same-cycle implication, masked during reset
`define PPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, active during reset
`define PPP_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppp_pkg.sv
// Package for the pinhole point projection block: widths, register codes,
// queue item and status types. No dependencies.
package ppp_pkg;

  localparam int COORD_W    = 32;
  localparam int D_W        = COORD_W + 1;
  localparam int PROD_W     = COORD_W + D_W;
  localparam int Q_W        = 43;
  localparam int MAG_W      = Q_W;
  localparam int QUO_W      = 32;
  localparam int DIV_STEPS  = QUO_W;
  localparam int REM_W      = MAG_W + QUO_W;
  localparam int INV_W      = 31;
  localparam int FRAC_SHIFT = 24;
  localparam int Q_FRAC     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAT_PAIR0   = 3'd0,
    REG_MAT_PAIR1   = 3'd1,
    REG_MAT_PAIR2   = 3'd2,
    REG_MAT_PAIR3   = 3'd3,
    REG_MAT22_EYE_X = 3'd4,
    REG_EYE_Y_Z     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             in_front;
    logic             neg_u;
    logic             neg_v;
    logic [MAG_W-1:0] mag_u;
    logic [MAG_W-1:0] mag_v;
    logic [MAG_W-1:0] den;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/ppp_ifs.sv
// Channel interfaces for the pinhole point projection block.
// Depends on ppp_pkg.
interface cfg_if import ppp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface point_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface proj_if import ppp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      in_front;
  logic signed [COORD_W-1:0] proj_u;
  logic signed [COORD_W-1:0] proj_v;
  logic [INV_W-1:0]          inv_depth;
  modport source (output valid, in_front, proj_u, proj_v, inv_depth, input ready);
  modport sink (input valid, in_front, proj_u, proj_v, inv_depth, output ready);
endinterface

// File: rtl/pinhole_point_projection.sv
// Pinhole point projection, top level: front end, queue, back end.
// Depends on ppp_pkg, ppp_ifs, ppp_front, ppp_queue, ppp_back and the defines header.
// Throughput: one item per cycle unless a low proj.ready or a full queue stalls it;
// the 32-stage divider pipeline sets the latency.
// Reset (rst, synchronous): config registers to zero, queue and pipelines empty.
`include "pinhole_point_projection_defines.svh"

module pinhole_point_projection import ppp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cfg_if.sink    cfg,
  point_if.sink  point,
  proj_if.source proj
);

  logic   push, pop;
  work_t  push_data, head;
  qstat_t qstat;

  ppp_front u_front (
    .clk, .rst, .cfg, .point, .qstat, .push, .push_data
  );

  ppp_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .qstat
  );

  ppp_back u_back (
    .clk, .rst, .head, .qstat, .pop, .proj
  );

  `PPP_ASSERT_IMP(a_push_room, clk, rst, push, !qstat.full, "item pushed into full queue")
  `PPP_ASSERT_IMP(a_pop_data, clk, rst, pop, !qstat.empty, "item popped from empty queue")
  `PPP_ASSERT_IMP(a_behind_zero, clk, rst, proj.valid && !proj.in_front, proj.proj_u == 0 && proj.proj_v == 0 && proj.inv_depth == 0, "behind-eye item not zeroed")
  `PPP_ASSERT_RST(a_reset_idle, clk, rst, !proj.valid, "result valid after reset")

endmodule

// File: rtl/ppp_front.sv
// Front end: configuration registers, eye offset, matrix product and
// classification of each point. Depends on ppp_pkg and ppp_ifs.
module ppp_front import ppp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cfg_if.sink    cfg,
  point_if.sink  point,
  input  qstat_t qstat,
  output logic   push,
  output work_t  push_data
);

  logic [CFG_DATA_W-1:0] mat_pair0, mat_pair1, mat_pair2, mat_pair3;
  logic [CFG_DATA_W-1:0] mat22_eye_x, eye_y_z;
  logic signed [COORD_W-1:0] m [3][3];
  logic signed [COORD_W-1:0] eye [3];
  logic signed [COORD_W-1:0] pin [3];

  logic                     en;
  logic                     a_valid, b_valid, c_valid;
  logic signed [D_W-1:0]    d [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [Q_W-1:0]    q [3];
  logic signed [Q_W-1:0]    q_next [3];
  logic                     front;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_pair0   <= '0;
      mat_pair1   <= '0;
      mat_pair2   <= '0;
      mat_pair3   <= '0;
      mat22_eye_x <= '0;
      eye_y_z     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAT_PAIR0:   mat_pair0   <= cfg.data;
        REG_MAT_PAIR1:   mat_pair1   <= cfg.data;
        REG_MAT_PAIR2:   mat_pair2   <= cfg.data;
        REG_MAT_PAIR3:   mat_pair3   <= cfg.data;
        REG_MAT22_EYE_X: mat22_eye_x <= cfg.data;
        REG_EYE_Y_Z:     eye_y_z     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    m[0][0] = mat_pair0[63:32];
    m[0][1] = mat_pair0[31:0];
    m[0][2] = mat_pair1[63:32];
    m[1][0] = mat_pair1[31:0];
    m[1][1] = mat_pair2[63:32];
    m[1][2] = mat_pair2[31:0];
    m[2][0] = mat_pair3[63:32];
    m[2][1] = mat_pair3[31:0];
    m[2][2] = mat22_eye_x[63:32];
    eye[0]  = mat22_eye_x[31:0];
    eye[1]  = eye_y_z[63:32];
    eye[2]  = eye_y_z[31:0];
    pin[0]  = point.point_x;
    pin[1]  = point.point_y;
    pin[2]  = point.point_z;
  end

  assign en          = !(c_valid && qstat.full);
  assign point.ready = en;
  assign push        = c_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= point.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_next[i] = '0;
      for (int j = 0; j < 3; j++) begin
        q_next[i] = q_next[i] + Q_W'(prod[i][j] >>> FRAC_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d[j] <= D_W'(pin[j]) - D_W'(eye[j]);
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= m[i][j] * d[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        q[i] <= q_next[i];
      end
    end
  end

  // behind or at the eye: zero magnitudes, harmless divisor
  assign front = !q[2][Q_W-1] && (q[2] != '0);

  always_comb begin
    push_data.in_front = front;
    push_data.neg_u    = q[0][Q_W-1];
    push_data.neg_v    = q[1][Q_W-1];
    push_data.mag_u    = '0;
    push_data.mag_v    = '0;
    push_data.den      = MAG_W'(1);
    if (front) begin
      push_data.mag_u = q[0][Q_W-1] ? MAG_W'(-q[0]) : MAG_W'(q[0]);
      push_data.mag_v = q[1][Q_W-1] ? MAG_W'(-q[1]) : MAG_W'(q[1]);
      push_data.den   = MAG_W'(q[2]);
    end
  end

endmodule

// File: rtl/ppp_queue.sv
// Short item queue between front and back ends.
// Depends on ppp_pkg.
module ppp_queue import ppp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  work_t  push_data,
  input  logic   pop,
  output work_t  head,
  output qstat_t qstat
);

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign head        = mem[rptr];
  assign qstat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients of 2^32 and up. Depends on ppp_pkg.
module ppp_div import ppp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag,
  input  logic [MAG_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [REM_W-1:0] rem [DIV_STEPS+1];
  logic [MAG_W-1:0] dd  [DIV_STEPS+1];
  logic [QUO_W-1:0] qq  [DIV_STEPS+1];
  logic             of  [DIV_STEPS+1];
  logic [REM_W-1:0] num;

  assign num = REM_W'(mag) << Q_FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      qq[0]  <= '0;
      of[0]  <= num >= (REM_W'(den) << QUO_W);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int B = DIV_STEPS - k;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(dd[k-1]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[k] <= dd[k-1];
        of[k] <= of[k-1];
        if (rem[k-1] >= trial) begin
          rem[k] <= rem[k-1] - trial;
          qq[k]  <= qq[k-1] | (QUO_W'(1) << B);
        end else begin
          rem[k] <= rem[k-1];
          qq[k]  <= qq[k-1];
        end
      end
    end
  end

  assign quo = qq[DIV_STEPS];
  assign ovf = of[DIV_STEPS];

endmodule

// File: rtl/ppp_back.sv
// Back end: three dividers for u, v and inverse depth, sign and
// saturation, output register. Depends on ppp_pkg, ppp_ifs, ppp_div.
module ppp_back import ppp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  work_t  head,
  input  qstat_t qstat,
  output logic   pop,
  proj_if.source proj
);

  logic             en;
  logic             sb_valid [DIV_STEPS+1];
  logic             sb_front [DIV_STEPS+1];
  logic             sb_neg_u [DIV_STEPS+1];
  logic             sb_neg_v [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_u, quo_v, quo_i;
  logic             ovf_u, ovf_v, ovf_i;
  logic [MAG_W-1:0] inv_num;

  assign en      = !proj.valid || proj.ready;
  assign pop     = en && !qstat.empty;
  assign inv_num = MAG_W'(1) << Q_FRAC;

  ppp_div u_div_u (.clk, .en, .mag(head.mag_u), .den(head.den), .quo(quo_u), .ovf(ovf_u));
  ppp_div u_div_v (.clk, .en, .mag(head.mag_v), .den(head.den), .quo(quo_v), .ovf(ovf_v));
  ppp_div u_div_i (.clk, .en, .mag(inv_num), .den(head.den), .quo(quo_i), .ovf(ovf_i));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) sb_valid[k] <= 1'b0;
    end else if (en) begin
      sb_valid[0] <= pop;
      for (int k = 1; k <= DIV_STEPS; k++) sb_valid[k] <= sb_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_front[0] <= head.in_front;
      sb_neg_u[0] <= head.neg_u;
      sb_neg_v[0] <= head.neg_v;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sb_front[k] <= sb_front[k-1];
        sb_neg_u[k] <= sb_neg_u[k-1];
        sb_neg_v[k] <= sb_neg_v[k-1];
      end
    end
  end

  function automatic logic [QUO_W-1:0] sat_signed(input logic neg, input logic ovf,
                                                  input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] r;
    if (neg) begin
      if (ovf || (q[QUO_W-1] && (q[QUO_W-2:0] != '0))) r = {1'b1, {(QUO_W-1){1'b0}}};
      else r = -q;
    end else begin
      if (ovf || q[QUO_W-1]) r = {1'b0, {(QUO_W-1){1'b1}}};
      else r = q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      proj.valid <= 1'b0;
    end else if (en) begin
      proj.valid <= sb_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj.in_front <= sb_front[DIV_STEPS];
      if (sb_front[DIV_STEPS]) begin
        proj.proj_u    <= sat_signed(sb_neg_u[DIV_STEPS], ovf_u, quo_u);
        proj.proj_v    <= sat_signed(sb_neg_v[DIV_STEPS], ovf_v, quo_v);
        proj.inv_depth <= (ovf_i || quo_i[QUO_W-1]) ? {INV_W{1'b1}} : quo_i[INV_W-1:0];
      end else begin
        proj.proj_u    <= '0;
        proj.proj_v    <= '0;
        proj.inv_depth <= '0;
      end
    end
  end

endmodule
